// ===== rtl/lar_pkg.sv =====
// Shared types, codes and defaults for the log admission ring queue.
// No dependencies; every other file in rtl/ but lar_ram refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lar_pkg;

    // Field widths fixed by the interface
    localparam int REQ_W      = 2;
    localparam int LEVEL_W    = 2;
    localparam int LEN_W      = 8;
    localparam int REF_W      = 16;
    localparam int TIME_W     = 32;
    localparam int ROOM_W     = 16;
    localparam int STAT_IDX_W = 3;
    localparam int STATUS_W   = 3;
    localparam int USB_ACT_W  = 2;
    localparam int UDP_LEN_W  = 11;
    localparam int STAT_W     = 32;
    localparam int NUM_STATS  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int BUDGET_W   = 16;
    localparam int WIN_LEN_W  = 16;

    // Parameter defaults
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_LINE_BYTES  = 256;
    localparam int DEF_BATCH_BYTES = 1280;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_ENQ   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DRAIN = 2'd2;
    localparam logic [REQ_W-1:0] REQ_STAT  = 2'd3;

    // Severity levels
    localparam logic [LEVEL_W-1:0] LVL_INFO  = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_DEBUG = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SUPPRESS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DRAINED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_STAT     = 3'd6;

    // USB sink actions
    localparam logic [USB_ACT_W-1:0] USB_NONE    = 2'd0;
    localparam logic [USB_ACT_W-1:0] USB_WRITTEN = 2'd1;
    localparam logic [USB_ACT_W-1:0] USB_DROPPED = 2'd2;
    localparam logic [USB_ACT_W-1:0] USB_SUSPEND = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INFO_BUDGET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USB_ENABLED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USB_SUSP_WIFI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_USB_SUSP_LVL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIFI_ACTIVE  = 3'd5;

    typedef struct packed {
        logic [BUDGET_W-1:0]  info_budget;
        logic [WIN_LEN_W-1:0] window_length_ms;
        logic                 usb_enabled;
        logic                 usb_suspend_on_wifi;
        logic [LEVEL_W-1:0]   usb_suspend_level;
        logic                 wifi_sink_active;
    } lar_cfg_t;

    localparam lar_cfg_t CFG_RESET = '{
        info_budget:         16'd20,
        window_length_ms:    16'd1000,
        usb_enabled:         1'b1,
        usb_suspend_on_wifi: 1'b1,
        usb_suspend_level:   2'd1,
        wifi_sink_active:    1'b0
    };

    // One ring slot
    typedef struct packed {
        logic [REF_W-1:0]   line_ref;
        logic [LEN_W-1:0]   line_length;
        logic [LEVEL_W-1:0] level;
    } lar_entry_t;

    // Captured request
    typedef struct packed {
        logic [REQ_W-1:0]      req_type;
        logic [LEVEL_W-1:0]    level;
        logic [LEN_W-1:0]      line_length;
        logic                  truncated;
        logic [REF_W-1:0]      line_ref;
        logic [TIME_W-1:0]     now_ms;
        logic                  armed;
        logic [ROOM_W-1:0]     usb_room;
        logic [STAT_IDX_W-1:0] stat_index;
    } lar_req_t;

    // Counter increments; bit position equals the counter index
    typedef struct packed {
        logic udp_line;
        logic usb_suspended;
        logic usb_dropped;
        logic usb_written;
        logic truncated;
        logic suppressed;
        logic dropped_full;
        logic enqueued;
    } lar_stat_inc_t;

endpackage

`default_nettype wire

// ===== rtl/log_admission_ring_queue_top.sv =====
// Top level of the log admission ring queue: request register, ring, policy, result register.
// Depends on lar_pkg, lar_ram, lar_window, lar_stats and lar_sink.
//
// Usage
//   Request channel (in_valid / in_stall): one request per accepted cycle, kind in
//   req_type: enqueue a line descriptor, pop the oldest line, end a drain, or read
//   a statistic. Every request produces exactly one result on the result channel
//   (out_valid / out_stall); fields a request does not produce read as zero.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data), to be
//   used only while no request is in flight.
//   out_valid rises once its accepted request has passed the request register
//   and then the result register. Throughput: one request per cycle unless out_stall
//   holds the result register; the ring is a registered-read RAM read ahead at the
//   next head slot, with a bypass register covering a write into that slot.
//   Stall: when out_stall holds the result register full, the request register
//   holds its request and in_stall rises; nothing is lost or repeated.
//   Reset (rst_n low, asynchronous): ring empty, rate window and counters zero,
//   batch empty, registers at their defaults. The ring RAM is not cleared; no
//   clearing pass is needed, the block takes requests right after reset.
//   The ring holds QUEUE_DEPTH-1 lines.
`timescale 1ns / 1ps
`default_nettype none

module log_admission_ring_queue_top #(
    parameter int QUEUE_DEPTH = lar_pkg::DEF_QUEUE_DEPTH,
    parameter int LINE_BYTES  = lar_pkg::DEF_LINE_BYTES,
    parameter int BATCH_BYTES = lar_pkg::DEF_BATCH_BYTES
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_write,
    input  wire logic [lar_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lar_pkg::CFG_DATA_W-1:0]     cfg_data,
    // request channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [lar_pkg::REQ_W-1:0]          req_type,
    input  wire logic [lar_pkg::LEVEL_W-1:0]        level,
    input  wire logic [lar_pkg::LEN_W-1:0]          line_length,
    input  wire logic                               truncated,
    input  wire logic [lar_pkg::REF_W-1:0]          line_ref,
    input  wire logic [lar_pkg::TIME_W-1:0]         now_ms,
    input  wire logic                               armed,
    input  wire logic [lar_pkg::ROOM_W-1:0]         usb_room,
    input  wire logic [lar_pkg::STAT_IDX_W-1:0]     stat_index,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [lar_pkg::STATUS_W-1:0]       status,
    output logic      [lar_pkg::REF_W-1:0]          out_line_ref,
    output logic      [lar_pkg::LEN_W-1:0]          out_line_length,
    output logic      [lar_pkg::LEVEL_W-1:0]        out_level,
    output logic      [lar_pkg::USB_ACT_W-1:0]      usb_action,
    output logic      [lar_pkg::UDP_LEN_W-1:0]      udp_flush_length,
    output logic                                    udp_appended,
    output logic      [lar_pkg::STAT_W-1:0]         stat_value
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [lar_pkg::UDP_LEN_W-1:0] LEN_MAX = lar_pkg::UDP_LEN_W'(LINE_BYTES - 1);
    localparam int ENTRY_W = $bits(lar_pkg::lar_entry_t);

    // ---------------- configuration registers ----------------
    lar_pkg::lar_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lar_pkg::CFG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lar_pkg::CFG_INFO_BUDGET:   cfg_reg.info_budget         <= cfg_data;
                lar_pkg::CFG_WINDOW_LEN:    cfg_reg.window_length_ms    <= cfg_data;
                lar_pkg::CFG_USB_ENABLED:   cfg_reg.usb_enabled         <= cfg_data[0];
                lar_pkg::CFG_USB_SUSP_WIFI: cfg_reg.usb_suspend_on_wifi <= cfg_data[0];
                lar_pkg::CFG_USB_SUSP_LVL:
                    cfg_reg.usb_suspend_level <= cfg_data[lar_pkg::LEVEL_W-1:0];
                lar_pkg::CFG_WIFI_ACTIVE:   cfg_reg.wifi_sink_active    <= cfg_data[0];
                default: ;  // unused indexes are ignored
            endcase
        end
    end

    // ---------------- request register ----------------
    logic              s1_valid_reg;
    lar_pkg::lar_req_t s1_reg;
    logic              out_valid_reg;
    logic              fire;      // request in s1 retires into the result register
    logic              in_take;

    assign fire     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_reg <= '{
                req_type:    req_type,
                level:       level,
                line_length: line_length,
                truncated:   truncated,
                line_ref:    line_ref,
                now_ms:      now_ms,
                armed:       armed,
                usb_room:    usb_room,
                stat_index:  stat_index
            };
        end
    end

    // ---------------- ring pointers and storage ----------------
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_inc;
    logic [PTR_W-1:0]    rd_ptr_inc;
    logic [PTR_W-1:0]    rd_addr;
    logic                ring_full;
    logic                ring_empty;
    logic                ram_we;
    lar_pkg::lar_entry_t wr_entry;
    logic [ENTRY_W-1:0]  ram_q;
    logic                byp_valid_reg;
    lar_pkg::lar_entry_t byp_entry_reg;
    lar_pkg::lar_entry_t head;

    logic is_enq;
    logic is_pop;
    logic is_drain;
    logic win_check;
    logic win_over;
    logic suppress;
    logic enq_ok;
    logic pop_ok;
    logic [lar_pkg::LEN_W-1:0] len_clip;

    always_comb
    begin
        wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        ring_full  = wr_ptr_inc == rd_ptr_reg;
        ring_empty = wr_ptr_reg == rd_ptr_reg;

        is_enq   = s1_reg.req_type == lar_pkg::REQ_ENQ;
        is_pop   = s1_reg.req_type == lar_pkg::REQ_POP;
        is_drain = s1_reg.req_type == lar_pkg::REQ_DRAIN;

        // clip to the longest line the store holds
        len_clip = ({3'b000, s1_reg.line_length} > LEN_MAX) ?
                   LEN_MAX[lar_pkg::LEN_W-1:0] : s1_reg.line_length;

        win_check = is_enq && s1_reg.armed && (s1_reg.level == lar_pkg::LVL_INFO);
        suppress  = is_enq && s1_reg.armed &&
                    ((s1_reg.level == lar_pkg::LVL_DEBUG) || (win_check && win_over));
        enq_ok    = is_enq && !suppress && !ring_full;
        pop_ok    = is_pop && !ring_empty;

        ram_we   = fire && enq_ok;
        wr_entry = '{line_ref: s1_reg.line_ref, line_length: len_clip, level: s1_reg.level};

        // read ahead at the slot the next request will see as head
        rd_addr = (fire && pop_ok) ? rd_ptr_inc : rd_ptr_reg;
        head    = byp_valid_reg ? byp_entry_reg : lar_pkg::lar_entry_t'(ram_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                wr_ptr_reg <= wr_ptr_inc;
            end
            if (fire && pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_inc;
            end
            // RAM returns old data on a same-address write; take the new entry instead
            byp_valid_reg <= ram_we && (wr_ptr_reg == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            byp_entry_reg <= wr_entry;
        end
    end

    lar_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // ---------------- policy units ----------------
    lar_window u_window (
        .clk              (clk),
        .rst_n            (rst_n),
        .check            (win_check),
        .advance          (fire),
        .now_ms           (s1_reg.now_ms),
        .info_budget      (cfg_reg.info_budget),
        .window_length_ms (cfg_reg.window_length_ms),
        .over_budget      (win_over)
    );

    logic [lar_pkg::USB_ACT_W-1:0] sink_usb;
    logic [lar_pkg::UDP_LEN_W-1:0] sink_flush;
    logic                          sink_appended;

    lar_sink #(
        .BATCH_BYTES (BATCH_BYTES)
    ) u_sink (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (fire),
        .pop          (pop_ok),
        .drain        (is_drain),
        .cfg          (cfg_reg),
        .line_length  (head.line_length),
        .level        (head.level),
        .usb_room     (s1_reg.usb_room),
        .usb_action   (sink_usb),
        .flush_length (sink_flush),
        .appended     (sink_appended)
    );

    lar_pkg::lar_stat_inc_t        stat_inc;
    logic [lar_pkg::STAT_W-1:0]    stat_rd;

    always_comb
    begin
        stat_inc.enqueued      = enq_ok;
        stat_inc.dropped_full  = is_enq && !suppress && ring_full;
        stat_inc.suppressed    = suppress;
        stat_inc.truncated     = is_enq && s1_reg.truncated;
        stat_inc.usb_written   = sink_usb == lar_pkg::USB_WRITTEN;
        stat_inc.usb_dropped   = sink_usb == lar_pkg::USB_DROPPED;
        stat_inc.usb_suspended = sink_usb == lar_pkg::USB_SUSPEND;
        stat_inc.udp_line      = sink_appended;
    end

    lar_stats u_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (fire),
        .inc      (stat_inc),
        .rd_index (s1_reg.stat_index),
        .rd_value (stat_rd)
    );

    // ---------------- result assembly ----------------
    logic [lar_pkg::STATUS_W-1:0]  res_status;
    lar_pkg::lar_entry_t           res_entry;
    logic [lar_pkg::USB_ACT_W-1:0] res_usb;
    logic [lar_pkg::UDP_LEN_W-1:0] res_flush;
    logic                          res_appended;
    logic [lar_pkg::STAT_W-1:0]    res_stat;

    always_comb
    begin
        res_status   = lar_pkg::ST_ACCEPTED;
        res_entry    = '0;
        res_usb      = lar_pkg::USB_NONE;
        res_flush    = '0;
        res_appended = 1'b0;
        res_stat     = '0;
        unique case (s1_reg.req_type)
            lar_pkg::REQ_ENQ:
            begin
                if (suppress)
                begin
                    res_status = lar_pkg::ST_SUPPRESS;
                end
                else if (ring_full)
                begin
                    res_status = lar_pkg::ST_FULL;
                end
                else
                begin
                    res_status = lar_pkg::ST_ACCEPTED;
                end
            end
            lar_pkg::REQ_POP:
            begin
                if (ring_empty)
                begin
                    res_status = lar_pkg::ST_EMPTY;
                end
                else
                begin
                    res_status   = lar_pkg::ST_POPPED;
                    res_entry    = head;
                    res_usb      = sink_usb;
                    res_flush    = sink_flush;
                    res_appended = sink_appended;
                end
            end
            lar_pkg::REQ_DRAIN:
            begin
                res_status = lar_pkg::ST_DRAINED;
                res_flush  = sink_flush;
            end
            lar_pkg::REQ_STAT:
            begin
                res_status = lar_pkg::ST_STAT;
                res_stat   = stat_rd;
            end
            default: ;
        endcase
    end

    // ---------------- result register ----------------
    logic [lar_pkg::STATUS_W-1:0]  status_reg;
    lar_pkg::lar_entry_t           entry_reg;
    logic [lar_pkg::USB_ACT_W-1:0] usb_reg;
    logic [lar_pkg::UDP_LEN_W-1:0] flush_reg;
    logic                          appended_reg;
    logic [lar_pkg::STAT_W-1:0]    stat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= res_status;
            entry_reg    <= res_entry;
            usb_reg      <= res_usb;
            flush_reg    <= res_flush;
            appended_reg <= res_appended;
            stat_reg     <= res_stat;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign out_line_ref     = entry_reg.line_ref;
    assign out_line_length  = entry_reg.line_length;
    assign out_level        = entry_reg.level;
    assign usb_action       = usb_reg;
    assign udp_flush_length = flush_reg;
    assign udp_appended     = appended_reg;
    assign stat_value       = stat_reg;

    // ---------------- assertions ----------------
    // Ring pointers stay inside the ring.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(wr_ptr_reg) < QUEUE_DEPTH) && (int'(rd_ptr_reg) < QUEUE_DEPTH))
        else $error("ring pointer out of range");

    // A retired pop of a non-empty ring moves the read pointer.
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && pop_ok) |=> (rd_ptr_reg != $past(rd_ptr_reg)))
        else $error("pop did not advance read pointer");

    // An accepted enqueue never leaves the ring looking empty.
    a_enq_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (wr_ptr_reg != rd_ptr_reg))
        else $error("enqueue left ring empty");

    // Bypass is only armed by a write in the previous cycle.
    a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
        byp_valid_reg |-> $past(ram_we))
        else $error("bypass without a ring write");

endmodule

`default_nettype wire

// ===== rtl/lar_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/lar_window.sv =====
// Info-line rate window: start time and count of armed info enqueues let through in it.
// Depends on lar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lar_window (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            check,    // armed info enqueue
    input  wire logic                            advance,  // request retires this cycle
    input  wire logic [lar_pkg::TIME_W-1:0]      now_ms,
    input  wire logic [lar_pkg::BUDGET_W-1:0]    info_budget,
    input  wire logic [lar_pkg::WIN_LEN_W-1:0]   window_length_ms,
    output logic                                 over_budget
);

    logic [lar_pkg::TIME_W-1:0]   start_reg;
    logic [lar_pkg::BUDGET_W-1:0] count_reg;
    logic [lar_pkg::TIME_W-1:0]   elapsed;
    logic                         restart;
    logic [lar_pkg::BUDGET_W-1:0] count_eff;

    always_comb
    begin
        elapsed     = now_ms - start_reg;
        restart     = elapsed >= {{(lar_pkg::TIME_W - lar_pkg::WIN_LEN_W){1'b0}},
                                  window_length_ms};
        count_eff   = restart ? '0 : count_reg;
        over_budget = count_eff >= info_budget;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            count_reg <= '0;
        end
        else if (check && advance)
        begin
            if (restart)
            begin
                start_reg <= now_ms;
            end
            count_reg <= over_budget ? count_eff : count_eff + 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lar_stats.sv =====
// Bank of eight wrapping 32-bit event counters with one read port.
// Depends on lar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lar_stats (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    input  wire lar_pkg::lar_stat_inc_t            inc,
    input  wire logic [lar_pkg::STAT_IDX_W-1:0]    rd_index,
    output logic      [lar_pkg::STAT_W-1:0]        rd_value
);

    logic [lar_pkg::STAT_W-1:0]    cnt_reg [lar_pkg::NUM_STATS];
    logic [lar_pkg::NUM_STATS-1:0] inc_vec;

    assign inc_vec  = inc;
    assign rd_value = cnt_reg[rd_index];

    for (genvar i = 0; i < lar_pkg::NUM_STATS; i++)
    begin : g_cnt
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg[i] <= '0;
            end
            else if (advance && inc_vec[i])
            begin
                cnt_reg[i] <= cnt_reg[i] + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lar_sink.sv =====
// Sink decisions for a popped line: USB action and UDP batch fill/flush; a drain flushes the batch.
// Holds the batch fill register. Depends on lar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lar_sink #(
    parameter int BATCH_BYTES = lar_pkg::DEF_BATCH_BYTES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            advance,
    input  wire logic                            pop,     // pop of a non-empty ring
    input  wire logic                            drain,
    input  wire lar_pkg::lar_cfg_t               cfg,
    input  wire logic [lar_pkg::LEN_W-1:0]       line_length,
    input  wire logic [lar_pkg::LEVEL_W-1:0]     level,
    input  wire logic [lar_pkg::ROOM_W-1:0]      usb_room,
    output logic      [lar_pkg::USB_ACT_W-1:0]   usb_action,
    output logic      [lar_pkg::UDP_LEN_W-1:0]   flush_length,
    output logic                                 appended
);

    localparam int FILL_W = $clog2(BATCH_BYTES + 1);
    localparam logic [FILL_W:0] BATCH_LIM = (FILL_W + 1)'(BATCH_BYTES);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] base;
    logic [FILL_W:0]   len_ext;
    logic [FILL_W:0]   sum;
    logic              suspended;

    always_comb
    begin
        suspended = cfg.usb_suspend_on_wifi && cfg.wifi_sink_active;
        if (!pop || !cfg.usb_enabled)
        begin
            usb_action = lar_pkg::USB_NONE;
        end
        else if (suspended && (level > cfg.usb_suspend_level))
        begin
            usb_action = lar_pkg::USB_SUSPEND;
        end
        else if (usb_room >= {{(lar_pkg::ROOM_W - lar_pkg::LEN_W){1'b0}}, line_length})
        begin
            usb_action = lar_pkg::USB_WRITTEN;
        end
        else
        begin
            usb_action = lar_pkg::USB_DROPPED;
        end
    end

    always_comb
    begin
        len_ext      = (FILL_W + 1)'(line_length);
        sum          = {1'b0, fill_reg} + len_ext;
        base         = fill_reg;
        flush_length = '0;
        appended     = 1'b0;
        fill_next    = fill_reg;
        if (pop && cfg.wifi_sink_active)
        begin
            if (sum > BATCH_LIM)
            begin
                flush_length = lar_pkg::UDP_LEN_W'(fill_reg);
                base         = '0;
            end
            if (len_ext <= BATCH_LIM)
            begin
                appended  = 1'b1;
                fill_next = base + FILL_W'(line_length);
            end
            else
            begin
                fill_next = base;
            end
        end
        else if (drain)
        begin
            // zero fill reports zero, which means no flush
            flush_length = lar_pkg::UDP_LEN_W'(fill_reg);
            fill_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (advance)
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire
